/* hw/rtl/ssh_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssh_pkg: shared types and constants of the selectable string hash
// Holds the hash selection codes, the register indexes, the multiplier
// constants and the request format carried from the front to the back.
// ----------------------------------------------------------------------------
package ssh_pkg;

    // Register indexes of the configuration port.
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_HASH_SELECT = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SLOT_MASK   = 1'b1;

    // Register widths.
    localparam int SEL_W  = 4;
    localparam int MASK_W = 16;
    localparam int CFG_W  = 16;
    localparam int CHAR_W = 8;

    // Hash selection codes; codes above SEL_MUL4555 mean constant zero.
    localparam logic [SEL_W-1:0] SEL_ZERO    = 4'd0;
    localparam logic [SEL_W-1:0] SEL_FIRST   = 4'd1;
    localparam logic [SEL_W-1:0] SEL_HEAD2   = 4'd2;
    localparam logic [SEL_W-1:0] SEL_HEAD3   = 4'd3;
    localparam logic [SEL_W-1:0] SEL_HEAD4   = 4'd4;
    localparam logic [SEL_W-1:0] SEL_SUM     = 4'd5;
    localparam logic [SEL_W-1:0] SEL_MUL5    = 4'd6;
    localparam logic [SEL_W-1:0] SEL_MUL37   = 4'd7;
    localparam logic [SEL_W-1:0] SEL_MUL43   = 4'd8;
    localparam logic [SEL_W-1:0] SEL_MUL4555 = 4'd9;

    // Multiplier constants of the running and head hashes.
    localparam int K_5     = 5;
    localparam int K_11    = 11;
    localparam int K_37    = 37;
    localparam int K_43    = 43;
    localparam int K_139   = 139;
    localparam int K_4555  = 'h4555;
    localparam int K_SHIFT = 8;

    // Head store: four characters, position count saturates at four.
    localparam int HEAD_N = 4;
    localparam int POS_W  = 3;
    localparam logic [POS_W-1:0] POS_FULL = 3'd4;

    // Width of the head hash sums (largest value stays below 2^16).
    localparam int HEAD_SUM_W = 16;

    // Depth of the request queue between front and back.
    localparam int QDEPTH = 2;

    // One request: a character or the string terminator.
    typedef struct packed {
        logic              term;
        logic [CHAR_W-1:0] ch;
    } ssh_req_t;

endpackage : ssh_pkg
`default_nettype wire

/* hw/rtl/selectable_string_hash.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// selectable_string_hash: streaming string hash with ten selectable functions
// Characters are pushed one per request; a zero character ends the string
// and produces one result holding the hash and the hash ANDed with the mask.
// ----------------------------------------------------------------------------
// The block takes one character per clock cycle, the terminator included, as
// long as each result is popped by the cycle in which the next terminator
// reaches the hash engine. A result that still waits holds that terminator
// back, the two-entry queue then fills with the characters behind it and full
// rises. A pushed character is first written into the request queue and is
// taken from there by the engine; the result register loads when the engine
// takes the terminator. The rate is set by the running hash update, at most
// one constant multiply, a shift and an add or xor per character. A
// two-entry request queue parts the input from the engine, and a
// one-entry result register parts the engine from the output. Configuration
// is written through wr_en, wr_index and wr_data and must only change while
// no string is in flight.
// ----------------------------------------------------------------------------
module selectable_string_hash
    import ssh_pkg::*;
#(
    parameter int SLOT_BITS  = 16,
    parameter int HASH_WIDTH = 32
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    input  wire logic [CHAR_W-1:0]      ch,
    output logic                        full,
    output logic                        empty,
    input  wire logic                   pop,
    output logic [HASH_WIDTH-1:0]       hash_value,
    output logic [SLOT_BITS-1:0]        slot,
    input  wire logic                   wr_en,
    input  wire logic [CFG_INDEX_W-1:0] wr_index,
    input  wire logic [CFG_W-1:0]       wr_data
);

    logic [SEL_W-1:0]  hash_select_reg, hash_select_next;
    logic [MASK_W-1:0] slot_mask_reg, slot_mask_next;
    logic              q_valid;
    logic              q_pop;
    ssh_req_t          q_req;

    // Configuration register writes.
    always_comb
    begin
        hash_select_next = hash_select_reg;
        slot_mask_next   = slot_mask_reg;
        if (wr_en)
        begin
            case (wr_index)
                CFG_HASH_SELECT: hash_select_next = wr_data[SEL_W-1:0];
                CFG_SLOT_MASK:   slot_mask_next   = wr_data[MASK_W-1:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_select_reg <= SEL_ZERO;
            slot_mask_reg   <= '0;
        end
        else
        begin
            hash_select_reg <= hash_select_next;
            slot_mask_reg   <= slot_mask_next;
        end
    end

    // Input side: classify and queue requests.
    ssh_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .ch      (ch),
        .full    (full),
        .q_valid (q_valid),
        .q_req   (q_req),
        .q_pop   (q_pop)
    );

    // Hash engine and result register.
    ssh_back #(
        .HASH_WIDTH (HASH_WIDTH),
        .SLOT_BITS  (SLOT_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_req       (q_req),
        .q_pop       (q_pop),
        .hash_select (hash_select_reg),
        .slot_mask   (slot_mask_reg),
        .pop         (pop),
        .empty       (empty),
        .hash_value  (hash_value),
        .slot        (slot)
    );

endmodule : selectable_string_hash
`default_nettype wire

/* hw/rtl/ssh_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssh_front: input side of the string hash
// Accepts characters, marks the terminator and holds the requests in a
// short queue until the back takes them.
// ----------------------------------------------------------------------------
module ssh_front
    import ssh_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire logic [CHAR_W-1:0] ch,
    output logic                   full,
    output logic                   q_valid,
    output ssh_req_t               q_req,
    input  wire logic              q_pop
);

    localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CNT_W = $clog2(QDEPTH + 1);

    ssh_req_t           slot_reg [QDEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               push_ok;
    ssh_req_t           new_req;

    // Classify the incoming character.
    always_comb
    begin
        new_req.term = (ch == '0);
        new_req.ch   = ch;
    end

    assign full    = (count_reg == CNT_W'(QDEPTH));
    assign q_valid = (count_reg != '0);
    assign q_req   = slot_reg[rd_ptr_reg];
    assign push_ok = push && !full;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_ok)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push_ok && !q_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push_ok && q_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            slot_reg[wr_ptr_reg] <= new_req;
        end
    end

endmodule : ssh_front
`default_nettype wire

/* hw/rtl/ssh_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssh_back: hash engine of the string hash
// Folds each character into the running value and the head store, and on
// the terminator forms the selected hash into the result register.
// ----------------------------------------------------------------------------
module ssh_back
    import ssh_pkg::*;
#(
    parameter int HASH_WIDTH = 32,
    parameter int SLOT_BITS  = 16
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  q_valid,
    input  wire ssh_req_t              q_req,
    output logic                       q_pop,
    input  wire logic [SEL_W-1:0]      hash_select,
    input  wire logic [MASK_W-1:0]     slot_mask,
    input  wire logic                  pop,
    output logic                       empty,
    output logic [HASH_WIDTH-1:0]      hash_value,
    output logic [SLOT_BITS-1:0]       slot
);

    logic [HASH_WIDTH-1:0] run_reg, run_next;
    logic [CHAR_W-1:0]     head_reg [HEAD_N];
    logic [CHAR_W-1:0]     head_next [HEAD_N];
    logic [POS_W-1:0]      pos_reg, pos_next;
    logic                  out_valid_reg, out_valid_next;
    logic [HASH_WIDTH-1:0] hash_reg;
    logic [SLOT_BITS-1:0]  slot_reg;

    logic                  take;
    logic [HASH_WIDTH-1:0] ch_ext;
    logic [HASH_WIDTH-1:0] stepped;
    logic [HASH_WIDTH-1:0] final_hash;
    logic [HEAD_SUM_W-1:0] c0, c1, c2, c3;
    logic [HEAD_SUM_W-1:0] sum2, sum3, sum4;
    logic [HEAD_SUM_W-1:0] head_hash;
    logic [63:0]           hash_wide;
    logic [63:0]           mask_wide;

    // A character is always taken; a terminator needs room in the result register.
    assign take  = q_valid && (!q_req.term || !out_valid_reg || pop);
    assign q_pop = take;
    assign empty = !out_valid_reg;
    assign hash_value = hash_reg;
    assign slot       = slot_reg;

    assign ch_ext = HASH_WIDTH'(q_req.ch);

    // One step of the running hash.
    always_comb
    begin
        case (hash_select)
            SEL_SUM:     stepped = run_reg + ch_ext;
            SEL_MUL5:    stepped = (run_reg * HASH_WIDTH'(K_5)) + ch_ext;
            SEL_MUL37:   stepped = (run_reg * HASH_WIDTH'(K_37)) ^ ch_ext;
            SEL_MUL43:   stepped = (run_reg * HASH_WIDTH'(K_43)) ^ ch_ext;
            SEL_MUL4555: stepped = ((run_reg * HASH_WIDTH'(K_4555)) >> K_SHIFT) ^ ch_ext;
            default:     stepped = run_reg;
        endcase
    end

    // Weighted sums over the head characters.
    always_comb
    begin
        c0   = HEAD_SUM_W'(head_reg[0]);
        c1   = HEAD_SUM_W'(head_reg[1]);
        c2   = HEAD_SUM_W'(head_reg[2]);
        c3   = HEAD_SUM_W'(head_reg[3]);
        sum2 = c0 * HEAD_SUM_W'(K_139) + c1;
        sum3 = c0 * HEAD_SUM_W'(K_139) + c1 * HEAD_SUM_W'(K_37) + c2;
        sum4 = sum3 + c2 * HEAD_SUM_W'(K_11 - 1) + c3;
    end

    // Head hash chosen by selection and string length.
    always_comb
    begin
        head_hash = '0;
        if (hash_select == SEL_HEAD2)
        begin
            if (pos_reg != '0)
            begin
                head_hash = c0 * HEAD_SUM_W'(K_37) + c1;
            end
        end
        else if (pos_reg == POS_W'(1))
        begin
            head_hash = c0;
        end
        else if (pos_reg == POS_W'(2))
        begin
            head_hash = sum2;
        end
        else if (pos_reg == POS_W'(3) || hash_select == SEL_HEAD3)
        begin
            if (pos_reg != '0)
            begin
                head_hash = sum3;
            end
        end
        else if (pos_reg != '0)
        begin
            head_hash = sum4;
        end
    end

    // Final hash of the finished string.
    always_comb
    begin
        case (hash_select) inside
            SEL_FIRST:                    final_hash = HASH_WIDTH'(head_reg[0]);
            SEL_HEAD2, SEL_HEAD3, SEL_HEAD4: final_hash = HASH_WIDTH'(head_hash);
            [SEL_SUM:SEL_MUL4555]:        final_hash = run_reg;
            default:                      final_hash = '0;
        endcase
    end

    assign hash_wide = 64'(final_hash);
    assign mask_wide = 64'(slot_mask);

    // String state and result flag update.
    always_comb
    begin
        run_next       = run_reg;
        pos_next       = pos_reg;
        head_next      = head_reg;
        out_valid_next = out_valid_reg;
        if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end
        if (take)
        begin
            if (q_req.term)
            begin
                out_valid_next = 1'b1;
                run_next       = '0;
                pos_next       = '0;
                for (int i = 0; i < HEAD_N; i++)
                begin
                    head_next[i] = '0;
                end
            end
            else
            begin
                run_next = stepped;
                if (pos_reg < POS_FULL)
                begin
                    head_next[pos_reg[1:0]] = q_req.ch;
                    pos_next                = pos_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg       <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < HEAD_N; i++)
            begin
                head_reg[i] <= '0;
            end
        end
        else
        begin
            run_reg       <= run_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
            head_reg      <= head_next;
        end
    end

    // Result payload is loaded on each terminator.
    always_ff @(posedge clk)
    begin
        if (take && q_req.term)
        begin
            hash_reg <= final_hash;
            slot_reg <= SLOT_BITS'(hash_wide & mask_wide);
        end
    end

endmodule : ssh_back
`default_nettype wire
